@@ rtl/audio_bandpass_gain_saturate_assert.svh @@
// assertion macros shared by the band-pass filter modules
`ifndef AUDIO_BANDPASS_GAIN_SATURATE_ASSERT_SVH
`define AUDIO_BANDPASS_GAIN_SATURATE_ASSERT_SVH

// same-cycle implication
`define ABGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abgs assertion failed");

// next-cycle implication
`define ABGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abgs assertion failed");

`endif

@@ rtl/abgs_pkg.sv @@
// types, constants and microcode program of the band-pass filter
`default_nettype none
package abgs_pkg;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 16;
    localparam int SMP_W    = 24;
    localparam int WGT_W    = 9;
    localparam int GAIN_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int PC_W     = 4;
    localparam int PROD_W   = 36;
    localparam int DIVN_W   = 32;

    localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_B  = 3'd4;

    localparam logic [GAIN_W-1:0] RST_GAIN     = 8'd255;
    localparam logic [WGT_W-1:0]  RST_SMOOTH_A = 9'd150;
    localparam logic [WGT_W-1:0]  RST_SMOOTH_B = 9'd150;
    localparam logic [WGT_W-1:0]  RST_TRACK_A  = 9'd25;
    localparam logic [WGT_W-1:0]  RST_TRACK_B  = 9'd50;

    // micro-operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_ACC   = 4'd3;
    localparam logic [3:0] OP_DIFF  = 4'd4;
    localparam logic [3:0] OP_GMUL  = 4'd5;
    localparam logic [3:0] OP_NLOAD = 4'd6;
    localparam logic [3:0] OP_DSTEP = 4'd7;
    localparam logic [3:0] OP_OUT   = 4'd8;

    // step conditions: hold the step until true
    localparam logic [1:0] C_ALWAYS = 2'd0;
    localparam logic [1:0] C_IN     = 2'd1;
    localparam logic [1:0] C_NSMALL = 2'd2;
    localparam logic [1:0] C_OFREE  = 2'd3;

    // stage selects
    localparam logic [1:0] ST_SMOOTH_A = 2'd0;
    localparam logic [1:0] ST_SMOOTH_B = 2'd1;
    localparam logic [1:0] ST_TRACK_A  = 2'd2;
    localparam logic [1:0] ST_TRACK_B  = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] P_LOAD = 4'd0;
    localparam logic [PC_W-1:0] P_DIV  = 4'd12;
    localparam logic [PC_W-1:0] P_OUT  = 4'd13;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      sel;
        logic [1:0]      cond;
        logic            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
        logic       go;
    } t_ctrl;

    typedef struct packed {
        logic n_small;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [WGT_W-1:0]  w_sa;
        logic [WGT_W-1:0]  w_sb;
        logic [WGT_W-1:0]  w_ta;
        logic [WGT_W-1:0]  w_tb;
    } t_cfg;

    function automatic t_uword abgs_rom(input logic [PC_W-1:0] pc);
        t_uword u;
        u = '{op: OP_NOP, sel: ST_SMOOTH_A, cond: C_ALWAYS, jmp: 1'b1, target: P_LOAD};
        case (pc)
            4'd0:  u = '{OP_LOAD,  ST_SMOOTH_A, C_IN,     1'b0, P_LOAD};
            4'd1:  u = '{OP_MUL,   ST_SMOOTH_A, C_ALWAYS, 1'b0, P_LOAD};
            4'd2:  u = '{OP_ACC,   ST_SMOOTH_A, C_ALWAYS, 1'b0, P_LOAD};
            4'd3:  u = '{OP_MUL,   ST_SMOOTH_B, C_ALWAYS, 1'b0, P_LOAD};
            4'd4:  u = '{OP_ACC,   ST_SMOOTH_B, C_ALWAYS, 1'b0, P_LOAD};
            4'd5:  u = '{OP_MUL,   ST_TRACK_A,  C_ALWAYS, 1'b0, P_LOAD};
            4'd6:  u = '{OP_ACC,   ST_TRACK_A,  C_ALWAYS, 1'b0, P_LOAD};
            4'd7:  u = '{OP_MUL,   ST_TRACK_B,  C_ALWAYS, 1'b0, P_LOAD};
            4'd8:  u = '{OP_ACC,   ST_TRACK_B,  C_ALWAYS, 1'b0, P_LOAD};
            4'd9:  u = '{OP_DIFF,  ST_SMOOTH_A, C_ALWAYS, 1'b0, P_LOAD};
            4'd10: u = '{OP_GMUL,  ST_SMOOTH_A, C_ALWAYS, 1'b0, P_LOAD};
            4'd11: u = '{OP_NLOAD, ST_SMOOTH_A, C_ALWAYS, 1'b0, P_LOAD};
            4'd12: u = '{OP_DSTEP, ST_SMOOTH_A, C_NSMALL, 1'b0, P_LOAD};
            4'd13: u = '{OP_OUT,   ST_SMOOTH_A, C_OFREE,  1'b1, P_LOAD};
            default: u = '{OP_NOP, ST_SMOOTH_A, C_ALWAYS, 1'b1, P_LOAD};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

@@ rtl/abgs_cfg.sv @@
// configuration registers with weight clamping
`default_nettype none
module abgs_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [abgs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [abgs_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output abgs_pkg::t_cfg                        o_cfg
);

    logic [abgs_pkg::GAIN_W-1:0] r_gain;
    logic [abgs_pkg::WGT_W-1:0]  r_sa;
    logic [abgs_pkg::WGT_W-1:0]  r_sb;
    logic [abgs_pkg::WGT_W-1:0]  r_ta;
    logic [abgs_pkg::WGT_W-1:0]  r_tb;
    logic [abgs_pkg::WGT_W-1:0]  w_ta_c;
    logic [abgs_pkg::WGT_W-1:0]  w_tb_c;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= abgs_pkg::RST_GAIN;
            r_sa   <= abgs_pkg::RST_SMOOTH_A;
            r_sb   <= abgs_pkg::RST_SMOOTH_B;
            r_ta   <= abgs_pkg::RST_TRACK_A;
            r_tb   <= abgs_pkg::RST_TRACK_B;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                abgs_pkg::CFG_GAIN:     r_gain <= i_cfg_data[abgs_pkg::GAIN_W-1:0];
                abgs_pkg::CFG_SMOOTH_A: r_sa   <= i_cfg_data;
                abgs_pkg::CFG_SMOOTH_B: r_sb   <= i_cfg_data;
                abgs_pkg::CFG_TRACK_A:  r_ta   <= i_cfg_data;
                abgs_pkg::CFG_TRACK_B:  r_tb   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // weights above one act as one; tracking weights give the share kept
    assign w_ta_c = (r_ta > abgs_pkg::WGT_ONE) ? abgs_pkg::WGT_ONE : r_ta;
    assign w_tb_c = (r_tb > abgs_pkg::WGT_ONE) ? abgs_pkg::WGT_ONE : r_tb;

    assign o_cfg.gain = r_gain;
    assign o_cfg.w_sa = (r_sa > abgs_pkg::WGT_ONE) ? abgs_pkg::WGT_ONE : r_sa;
    assign o_cfg.w_sb = (r_sb > abgs_pkg::WGT_ONE) ? abgs_pkg::WGT_ONE : r_sb;
    assign o_cfg.w_ta = abgs_pkg::WGT_ONE - w_ta_c;
    assign o_cfg.w_tb = abgs_pkg::WGT_ONE - w_tb_c;

endmodule
`default_nettype wire

@@ rtl/abgs_seq.sv @@
// microcode sequencer: step counter, control store and jumps
`default_nettype none
module abgs_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  abgs_pkg::t_stat     i_stat,
    output logic                o_ready,
    output abgs_pkg::t_ctrl     o_ctrl
);

    `include "audio_bandpass_gain_saturate_assert.svh"

    localparam int PCW = abgs_pkg::PC_W;

    logic [abgs_pkg::PC_W-1:0] r_pc;
    logic [abgs_pkg::PC_W-1:0] n_pc;
    abgs_pkg::t_uword          w_u;
    logic                      w_go;

    assign w_u = abgs_pkg::abgs_rom(r_pc);

    always_comb begin
        case (w_u.cond)
            abgs_pkg::C_ALWAYS: w_go = 1'b1;
            abgs_pkg::C_IN:     w_go = i_in_valid;
            abgs_pkg::C_NSMALL: w_go = i_stat.n_small;
            abgs_pkg::C_OFREE:  w_go = i_stat.out_free;
            default:            w_go = 1'b1;
        endcase
        if (!w_go) begin
            n_pc = r_pc;
        end else if (w_u.jmp) begin
            n_pc = w_u.target;
        end else begin
            n_pc = r_pc + PCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= abgs_pkg::P_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ready     = (r_pc == abgs_pkg::P_LOAD);
    assign o_ctrl.op   = w_u.op;
    assign o_ctrl.sel  = w_u.sel;
    assign o_ctrl.go   = w_go;

    `ABGS_ASSERT_NXT(a_load_adv, i_clk, i_rst_n,
        (r_pc == abgs_pkg::P_LOAD) && i_in_valid, r_pc == abgs_pkg::P_LOAD + PCW'(1))
    `ABGS_ASSERT_NXT(a_out_wrap, i_clk, i_rst_n,
        (r_pc == abgs_pkg::P_OUT) && i_stat.out_free, r_pc == abgs_pkg::P_LOAD)
    `ABGS_ASSERT_NXT(a_div_hold, i_clk, i_rst_n,
        (r_pc == abgs_pkg::P_DIV) && !i_stat.n_small, r_pc == abgs_pkg::P_DIV)

endmodule
`default_nettype wire

@@ rtl/abgs_dp.sv @@
// datapath: stage registers, shared multiplier, divide by 255, saturation
`default_nettype none
module abgs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  abgs_pkg::t_ctrl                    i_ctrl,
    input  abgs_pkg::t_cfg                     i_cfg,
    input  wire logic [abgs_pkg::IN_W-1:0]     i_word,
    input  wire logic                          i_out_take,
    output abgs_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [abgs_pkg::OUT_W-1:0]         o_data
);

    `include "audio_bandpass_gain_saturate_assert.svh"

    localparam int SW = abgs_pkg::SMP_W;
    localparam int PW = abgs_pkg::PROD_W;
    localparam int NW = abgs_pkg::DIVN_W;

    logic signed [SW-1:0]  r_x, r_s1, r_s2, r_t1, r_t2;
    logic signed [SW-1:0]  n_x, n_s1, n_s2, n_t1, n_t2;
    logic signed [PW-1:0]  r_prod, n_prod;
    logic [SW:0]           r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [NW-1:0]         r_n, n_n;
    logic [SW-1:0]         r_q, n_q;
    logic [abgs_pkg::OUT_W-1:0] r_out, n_out;
    logic                  r_ovalid, n_ovalid;

    logic signed [SW-1:0]  w_old, w_fresh;
    logic [abgs_pkg::WGT_W-1:0] w_wgt;
    logic signed [SW:0]    w_delta;
    logic signed [SW+1:0]  w_ma;
    logic signed [abgs_pkg::WGT_W:0] w_mb;
    logic signed [PW-1:0]  w_acc;
    logic signed [SW-1:0]  w_res;
    logic signed [SW:0]    w_diff;
    logic [NW-1:0]         w_fold;
    logic                  w_load;
    logic                  w_emit;

    assign w_load = (i_ctrl.op == abgs_pkg::OP_LOAD) && i_ctrl.go;
    assign w_emit = (i_ctrl.op == abgs_pkg::OP_OUT) && i_ctrl.go;

    always_comb begin
        case (i_ctrl.sel)
            abgs_pkg::ST_SMOOTH_A: begin
                w_old = r_s1; w_fresh = r_x;  w_wgt = i_cfg.w_sa;
            end
            abgs_pkg::ST_SMOOTH_B: begin
                w_old = r_s2; w_fresh = r_s1; w_wgt = i_cfg.w_sb;
            end
            abgs_pkg::ST_TRACK_A: begin
                w_old = r_t1; w_fresh = r_s2; w_wgt = i_cfg.w_ta;
            end
            default: begin
                w_old = r_t2; w_fresh = r_t1; w_wgt = i_cfg.w_tb;
            end
        endcase
    end

    // old*(256-w) + fresh*w == old*256 + (fresh-old)*w
    assign w_delta = {w_fresh[SW-1], w_fresh} - {w_old[SW-1], w_old};

    always_comb begin
        if (i_ctrl.op == abgs_pkg::OP_GMUL) begin
            w_ma = $signed({1'b0, r_mag});
            w_mb = $signed({2'b00, i_cfg.gain});
        end else begin
            w_ma = $signed({w_delta[SW], w_delta});
            w_mb = $signed({1'b0, w_wgt});
        end
    end

    assign w_acc  = $signed({{(PW-SW-8){w_old[SW-1]}}, w_old, 8'h00}) + r_prod;
    // shift down by 8, rounding toward zero
    assign w_res  = $signed(w_acc[SW+7:8])
                  + $signed({{(SW-1){1'b0}}, w_acc[PW-1] && (w_acc[7:0] != 8'h00)});
    assign w_diff = {r_s2[SW-1], r_s2} - {r_t2[SW-1], r_t2};
    assign w_fold = NW'(r_n[NW-1:8]) + NW'(r_n[7:0]);

    always_comb begin
        n_x      = r_x;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_t1     = r_t1;
        n_t2     = r_t2;
        n_prod   = r_prod;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_n      = r_n;
        n_q      = r_q;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_out_take;
        case (i_ctrl.op)
            abgs_pkg::OP_LOAD: begin
                if (w_load) begin
                    n_x = $signed(i_word[abgs_pkg::IN_W-1:8])
                        + $signed({{(SW-1){1'b0}},
                                   i_word[abgs_pkg::IN_W-1] && (i_word[7:0] != 8'h00)});
                end
            end
            abgs_pkg::OP_MUL, abgs_pkg::OP_GMUL: begin
                n_prod = w_ma * w_mb;
            end
            abgs_pkg::OP_ACC: begin
                case (i_ctrl.sel)
                    abgs_pkg::ST_SMOOTH_A: n_s1 = w_res;
                    abgs_pkg::ST_SMOOTH_B: n_s2 = w_res;
                    abgs_pkg::ST_TRACK_A:  n_t1 = w_res;
                    default:               n_t2 = w_res;
                endcase
            end
            abgs_pkg::OP_DIFF: begin
                n_neg = w_diff[SW];
                n_mag = w_diff[SW] ? (SW+1)'(0) - w_diff : w_diff;
            end
            abgs_pkg::OP_NLOAD: begin
                n_n = r_prod[NW-1:0];
                n_q = '0;
            end
            abgs_pkg::OP_DSTEP: begin
                // n = 255*h + (h+l): move h into the quotient, keep h+l
                if (r_n[NW-1:8] != '0) begin
                    n_q = r_q + r_n[NW-1:8];
                    n_n = w_fold;
                end else if (r_n[7:0] == 8'hFF) begin
                    n_q = r_q + SW'(1);
                    n_n = '0;
                end
            end
            abgs_pkg::OP_OUT: begin
                if (w_emit) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_out = (r_q > SW'(32768)) ? 16'h8000 : 16'(SW'(0) - r_q);
                    end else begin
                        n_out = (r_q > SW'(32767)) ? 16'h7FFF : r_q[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2     <= '0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_prod <= n_prod;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_n    <= n_n;
        r_q    <= n_q;
        r_out  <= n_out;
    end

    assign o_stat.n_small  = (r_n < NW'(255));
    assign o_stat.out_free = !r_ovalid || i_out_take;
    assign o_valid         = r_ovalid;
    assign o_data          = r_out;

    `ABGS_ASSERT_NXT(a_div_shrinks, i_clk, i_rst_n,
        (i_ctrl.op == abgs_pkg::OP_DSTEP) && (r_n >= NW'(255)), r_n < $past(r_n))
    `ABGS_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, w_emit, r_ovalid)

endmodule
`default_nettype wire

@@ rtl/audio_bandpass_gain_saturate.sv @@
// Audio band-pass filter with gain and saturation. One signed 32-bit word
// is taken per transfer, scaled down to 24 bits, passed through two
// smoothing stages and two slow tracking stages, and the difference of the
// smoothed value and the slow track is scaled by gain/255 and clipped to
// signed 16 bits. A microcoded sequencer runs all stages on one shared
// 26x10 multiplier with a multiply and an accumulate step per stage, and
// repeats the divide-by-255 reduction step until the rest is below 255;
// the next sample is taken once the last result is in the output register.
// Configuration writes are accepted in every cycle.
`default_nettype none
module audio_bandpass_gain_saturate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,    // [31:0] sample_word
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,    // [15:0] out_sample
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);

    abgs_pkg::t_cfg  w_cfg;
    abgs_pkg::t_ctrl w_ctrl;
    abgs_pkg::t_stat w_stat;

    abgs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    abgs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_ready    (o_s_tready),
        .o_ctrl     (w_ctrl)
    );

    abgs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_cfg      (w_cfg),
        .i_word     (i_s_tdata),
        .i_out_take (i_m_tready),
        .o_stat     (w_stat),
        .o_valid    (o_m_tvalid),
        .o_data     (o_m_tdata)
    );

endmodule
`default_nettype wire
